>>> hdl/ctp_pkg.sv
package ctp_pkg;

  // Register field widths
  localparam int GAIN_W     = 10;
  localparam int THROTTLE_W = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MAX = 3'd4;

  // Reset values
  localparam logic [GAIN_W-1:0]     PROP_GAIN_RST    = 10'd100;
  localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST   = 10'd1;
  localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST   = 10'd5;
  localparam logic [THROTTLE_W-1:0] RAMP_STEP_RST    = 8'd2;
  localparam logic [THROTTLE_W-1:0] THROTTLE_MAX_RST = 8'd80;

  typedef struct packed {
    logic [GAIN_W-1:0]     prop_gain;
    logic [GAIN_W-1:0]     integ_gain;
    logic [GAIN_W-1:0]     deriv_gain;
    logic [THROTTLE_W-1:0] ramp_step;
    logic [THROTTLE_W-1:0] throttle_max;
  } cfg_t;

endpackage

>>> hdl/ctp_if.sv
interface ctp_in_if #(
  parameter int SPEED_WIDTH = 11
);
  logic                   valid;
  logic                   ready;
  logic                   brake_pressed;
  logic                   gas_pressed;
  logic                   cruise_on;
  logic [SPEED_WIDTH-1:0] speed;
  logic [SPEED_WIDTH-1:0] target_speed;

  modport source (
    output valid, brake_pressed, gas_pressed, cruise_on, speed, target_speed,
    input  ready
  );
  modport sink (
    input  valid, brake_pressed, gas_pressed, cruise_on, speed, target_speed,
    output ready
  );
endinterface

interface ctp_out_if;
  logic                            valid;
  logic                            ready;
  logic [ctp_pkg::THROTTLE_W-1:0]  throttle;

  modport source (
    output valid, throttle,
    input  ready
  );
  modport sink (
    input  valid, throttle,
    output ready
  );
endinterface

>>> hdl/ctp_cfg_regs.sv
module ctp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0] cfg_data,
  output ctp_pkg::cfg_t                  cfg
);
  import ctp_pkg::*;

  cfg_t cfg_r;

  // Decode the write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= PROP_GAIN_RST;
      cfg_r.integ_gain   <= INTEG_GAIN_RST;
      cfg_r.deriv_gain   <= DERIV_GAIN_RST;
      cfg_r.ramp_step    <= RAMP_STEP_RST;
      cfg_r.throttle_max <= THROTTLE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:    cfg_r.prop_gain    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg_r.integ_gain   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   cfg_r.deriv_gain   <= cfg_data[GAIN_W-1:0];
        REG_RAMP_STEP:    cfg_r.ramp_step    <= cfg_data[THROTTLE_W-1:0];
        REG_THROTTLE_MAX: cfg_r.throttle_max <= cfg_data[THROTTLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/ctp_pid.sv
module ctp_pid #(
  parameter int SPEED_WIDTH    = 11,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  ctp_pkg::cfg_t                        cfg,
  input  logic        [SPEED_WIDTH-1:0]        speed,
  input  logic        [SPEED_WIDTH-1:0]        target_speed,
  input  logic signed [INTEGRAL_WIDTH-1:0]     integral_in,
  input  logic signed [SPEED_WIDTH:0]          last_err_in,
  output logic signed [INTEGRAL_WIDTH-1:0]     integral_out,
  output logic signed [SPEED_WIDTH:0]          err_out,
  output logic        [ctp_pkg::THROTTLE_W-1:0] throttle
);
  import ctp_pkg::*;

  localparam int EW   = SPEED_WIDTH + 1;
  localparam int DW   = SPEED_WIDTH + 2;
  localparam int IW   = INTEGRAL_WIDTH;
  localparam int PPW  = GAIN_W + 1 + EW;
  localparam int IPW  = GAIN_W + 1 + IW;
  localparam int DPW  = GAIN_W + 1 + DW;
  localparam int SUMW = ((IPW > DPW) ? IPW : DPW) + 2;

  logic signed [EW-1:0]   err;
  logic signed [IW:0]     acc;
  logic signed [IW-1:0]   integ_sat;
  logic signed [DW-1:0]   deriv;
  logic signed [PPW-1:0]  p_prod;
  logic signed [IPW-1:0]  i_prod;
  logic signed [DPW-1:0]  d_prod;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] max_ext;

  // Speed error
  assign err = $signed({1'b0, target_speed}) - $signed({1'b0, speed});

  // Accumulate and saturate the integral at the signed limits
  assign acc = $signed({integral_in[IW-1], integral_in})
             + $signed({{(IW + 1 - EW){err[EW-1]}}, err});

  always_comb begin
    if (acc[IW] != acc[IW-1]) begin
      integ_sat = acc[IW] ? $signed({1'b1, {(IW - 1){1'b0}}})
                          : $signed({1'b0, {(IW - 1){1'b1}}});
    end else begin
      integ_sat = acc[IW-1:0];
    end
  end

  // Error change since the last cruise tick
  assign deriv = $signed({err[EW-1], err}) - $signed({last_err_in[EW-1], last_err_in});

  // Weighted terms
  assign p_prod = $signed({1'b0, cfg.prop_gain})  * err;
  assign i_prod = $signed({1'b0, cfg.integ_gain}) * integ_sat;
  assign d_prod = $signed({1'b0, cfg.deriv_gain}) * deriv;

  assign sum = $signed({{(SUMW - PPW){p_prod[PPW-1]}}, p_prod})
             + $signed({{(SUMW - IPW){i_prod[IPW-1]}}, i_prod})
             + $signed({{(SUMW - DPW){d_prod[DPW-1]}}, d_prod});

  assign max_ext = $signed({{(SUMW - THROTTLE_W){1'b0}}, cfg.throttle_max});

  // Clamp to zero through the maximum
  always_comb begin
    if (sum < 0) begin
      throttle = '0;
    end else if (sum > max_ext) begin
      throttle = cfg.throttle_max;
    end else begin
      throttle = sum[THROTTLE_W-1:0];
    end
  end

  assign integral_out = integ_sat;
  assign err_out      = err;

endmodule

>>> hdl/cruise_throttle_pid.sv
// Cruise throttle controller: one throttle command per control tick. A tick
// request is taken into a stage register, and its command is loaded into the
// output register when that register is empty or is being drained. One tick
// can be accepted every cycle while the output is not stalled. The PID
// datapath between the stage and output registers is combinational: the
// saturating integral add, three gain multipliers and the final clamp. Brake,
// then gas, then cruise set the mode; the integral and last error move only
// on cruise ticks. Write the gain registers only while no tick is in flight.
module cruise_throttle_pid #(
  parameter int SPEED_WIDTH    = 11,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ctp_in_if.sink                         in_req,
  ctp_out_if.source                      out_req,
  input  logic                           cfg_we,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctp_pkg::*;

  cfg_t cfg;

  // Stage register
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   s1_brake_r;
  logic                   s1_gas_r;
  logic                   s1_cruise_r;
  logic [SPEED_WIDTH-1:0] s1_speed_r;
  logic [SPEED_WIDTH-1:0] s1_target_r;

  // Controller state
  logic signed [INTEGRAL_WIDTH-1:0] integral_r;
  logic signed [INTEGRAL_WIDTH-1:0] integral_nxt;
  logic signed [SPEED_WIDTH:0]      last_err_r;
  logic signed [SPEED_WIDTH:0]      last_err_nxt;
  logic        [THROTTLE_W-1:0]     level_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [THROTTLE_W-1:0] out_throttle_r;

  logic                  in_take;
  logic                  s1_adv;
  logic                  cruise_sel;
  logic [THROTTLE_W:0]   gas_sum;
  logic [THROTTLE_W-1:0] gas_throttle;
  logic [THROTTLE_W-1:0] pid_throttle;
  logic [THROTTLE_W-1:0] throttle_nxt;

  ctp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ctp_pid #(
    .SPEED_WIDTH    (SPEED_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_pid (
    .cfg          (cfg),
    .speed        (s1_speed_r),
    .target_speed (s1_target_r),
    .integral_in  (integral_r),
    .last_err_in  (last_err_r),
    .integral_out (integral_nxt),
    .err_out      (last_err_nxt),
    .throttle     (pid_throttle)
  );

  // Handshake: advance the stage when the output register is free or drains
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_req.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign in_take      = in_req.valid && in_req.ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_req.ready ? 1'b0 : out_valid_r);

  // Gas ramp, capped at the maximum
  assign gas_sum      = {1'b0, level_r} + {1'b0, cfg.ramp_step};
  assign gas_throttle = (gas_sum > {1'b0, cfg.throttle_max}) ? cfg.throttle_max
                                                             : gas_sum[THROTTLE_W-1:0];

  // Select the mode by priority
  assign cruise_sel = !s1_brake_r && !s1_gas_r && s1_cruise_r;

  always_comb begin
    if (s1_brake_r) begin
      throttle_nxt = '0;
    end else if (s1_gas_r) begin
      throttle_nxt = gas_throttle;
    end else if (s1_cruise_r) begin
      throttle_nxt = pid_throttle;
    end else begin
      throttle_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      last_err_r  <= '0;
      level_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        level_r <= throttle_nxt;
        if (cruise_sel) begin
          integral_r <= integral_nxt;
          last_err_r <= last_err_nxt;
        end
      end
    end
  end

  // Payload registers: hold the request until it advances
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_brake_r  <= in_req.brake_pressed;
      s1_gas_r    <= in_req.gas_pressed;
      s1_cruise_r <= in_req.cruise_on;
      s1_speed_r  <= in_req.speed;
      s1_target_r <= in_req.target_speed;
    end
    if (s1_adv) begin
      out_throttle_r <= throttle_nxt;
    end
  end

  assign out_req.valid    = out_valid_r;
  assign out_req.throttle = out_throttle_r;

`ifndef SYNTH
  a_max_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_throttle_r <= $past(cfg.throttle_max))
    else $error("throttle above maximum");

  a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_brake_r) |=> out_throttle_r == '0)
    else $error("brake tick gave nonzero throttle");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !cruise_sel) |=> ($stable(integral_r) && $stable(last_err_r)))
    else $error("PID state moved on a non-cruise tick");

  a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_throttle_r == level_r)
    else $error("stored level differs from pending command");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_req.ready)
    else $error("stage empty but not ready");
`endif

endmodule
